// ===== hw/rtl/sspg_pkg.sv =====
// ----------------------------------------------------------------------------
// sspg_pkg
// Shared types, constants and the arctangent table for the scan point
// generator.
// ----------------------------------------------------------------------------
package sspg_pkg;

   // cordic datapath widths, 2^-30 units for x/y, 2^-32 turn for z
   localparam int LANE_WIDTH = 34;
   localparam int MAG_WIDTH  = LANE_WIDTH - 1;

   localparam logic [26:0] PHASE_MUL = 27'd42722830;
   localparam logic [31:0] CORDIC_X0 = 32'd652032874;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_INCL_MIN     = 3'd0,
      CSR_INCL_MAX     = 3'd1,
      CSR_INCL_STEP    = 3'd2,
      CSR_AZIM_MIN     = 3'd3,
      CSR_AZIM_MAX     = 3'd4,
      CSR_AZIM_STEP    = 3'd5,
      CSR_RADIUS_START = 3'd6,
      CSR_RADIUS_STEP  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic                         valid;
      logic signed [LANE_WIDTH-1:0] x;
      logic signed [LANE_WIDTH-1:0] y;
      logic signed [LANE_WIDTH-1:0] z;
   } cordic_lane_type;

   // atan(2^-i) in 2^-32 turn units
   function automatic logic signed [LANE_WIDTH-1:0] atan_entry(input int unsigned i);
      logic [29:0] v;
      case (i)
         0:  v = 30'd536870912;
         1:  v = 30'd316933406;
         2:  v = 30'd167458907;
         3:  v = 30'd85004756;
         4:  v = 30'd42667331;
         5:  v = 30'd21354465;
         6:  v = 30'd10679838;
         7:  v = 30'd5340245;
         8:  v = 30'd2670163;
         9:  v = 30'd1335087;
         10: v = 30'd667544;
         11: v = 30'd333772;
         12: v = 30'd166886;
         13: v = 30'd83443;
         14: v = 30'd41722;
         15: v = 30'd20861;
         16: v = 30'd10430;
         17: v = 30'd5215;
         18: v = 30'd2607;
         19: v = 30'd1303;
         20: v = 30'd651;
         21: v = 30'd325;
         22: v = 30'd162;
         23: v = 30'd81;
         24: v = 30'd40;
         25: v = 30'd20;
         26: v = 30'd10;
         27: v = 30'd5;
         28: v = 30'd2;
         29: v = 30'd1;
         default: v = 30'd0;
      endcase
      return $signed({{(LANE_WIDTH-30){1'b0}}, v});
   endfunction

endpackage

// ===== hw/rtl/sspg_if.sv =====
// ----------------------------------------------------------------------------
// sspg channel interfaces
// Valid/ready channels for requests, result points and register writes.
// ----------------------------------------------------------------------------
interface sspg_req_if;
   logic valid;
   logic ready;
   logic restart;
   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface sspg_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic               end_of_ring;
   logic               last_point;
   modport source (output valid, output pos_x, output pos_y, output pos_z,
                   output end_of_ring, output last_point, input ready);
   modport sink (input valid, input pos_x, input pos_y, input pos_z,
                 input end_of_ring, input last_point, output ready);
endinterface

interface sspg_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/spherical_scan_point_generator_top.sv =====
// ----------------------------------------------------------------------------
// spherical_scan_point_generator_top
// Walks an azimuth/inclination scan and emits at most one cartesian point per request.
// ----------------------------------------------------------------------------
// channel   dir  payload                                  accepted when
// req_chan  in   restart                                  valid & ready
// rsp_chan  out  pos_x, pos_y, pos_z, end_of_ring, last    valid & ready
// csr_chan  in   index (3b), data (32b)                   valid & ready
//
// a point runs from request to result through the chain of cordic cells
// that both angles pass through side by side.
// a request that yields no point returns the block to idle from the start state.
// one request is in flight at a time; the result register lets the next
// request in while the point waits, and a stalled result holds the last stage.
// reset is synchronous and restores the register defaults and an idle scan.
// ----------------------------------------------------------------------------
module spherical_scan_point_generator_top
   import sspg_pkg::*;
#(
   parameter int ANGLE_WIDTH  = 24,
   parameter int RADIUS_WIDTH = 32,
   parameter int CORDIC_STEPS = 20
) (
   input logic         clock,
   input logic         reset,
   sspg_req_if.sink    req_chan,
   sspg_rsp_if.source  rsp_chan,
   sspg_csr_if.sink    csr_chan
);

   localparam int CW  = 36;
   localparam int SW  = ((RADIUS_WIDTH > 32) ? RADIUS_WIDTH : 32) + 1;
   localparam int P1W = RADIUS_WIDTH + MAG_WIDTH;
   localparam int M1W = P1W - 29;
   localparam int P2W = M1W + MAG_WIDTH;
   localparam int M2W = P2W - 29;
   localparam logic [RADIUS_WIDTH-1:0] RMAX = {RADIUS_WIDTH{1'b1}};
   localparam logic signed [CW-1:0] ANG_HI = $signed(CW'(1) << (ANGLE_WIDTH - 1));
   localparam logic signed [CW-1:0] ANG_LO = -ANG_HI;

   typedef enum logic [2:0] {
      ST_IDLE, ST_START, ST_LAUNCH, ST_RUN, ST_MUL1, ST_RND1, ST_MUL2, ST_DONE
   } state_type;

   // registers
   logic signed [23:0]        incl_min_ff, incl_max_ff, azim_min_ff, azim_max_ff;
   logic [22:0]               incl_step_ff, azim_step_ff;
   logic [31:0]               radius_start_ff, radius_step_ff;

   state_type                 state_ff;
   logic                      scanning_ff;
   logic signed [ANGLE_WIDTH-1:0] azim_ff, incl_ff;
   logic [RADIUS_WIDTH-1:0]   radius_ff;

   logic [31:0]               phase_inc_ff, phase_az_ff;
   logic                      flip_inc_ff, flip_az_ff;
   logic [RADIUS_WIDTH-1:0]   item_radius_ff;
   logic                      eor_ff, last_ff;
   logic [MAG_WIDTH-1:0]      ci_mag_ff, si_mag_ff, ca_mag_ff, sa_mag_ff;
   logic                      ci_neg_ff, si_neg_ff, ca_neg_ff, sa_neg_ff;
   logic [P1W-1:0]            prod_rc_ff, prod_z_ff;
   logic [M1W-1:0]            rc_mag_ff;
   logic                      rc_neg_ff;
   logic signed [31:0]        z_ff;
   logic [P2W-1:0]            prod_x_ff, prod_y_ff;

   logic                      rsp_valid_ff;
   logic signed [31:0]        rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic                      rsp_eor_ff, rsp_last_ff;

   // cordic chain
   cordic_lane_type inc_lane [0:CORDIC_STEPS];
   cordic_lane_type az_lane  [0:CORDIC_STEPS];

   genvar gi;
   generate
      for (gi = 0; gi < CORDIC_STEPS; gi++) begin : g_cell
         sspg_cordic_cell #(.STEP(gi)) u_inc_cell (
            .clock(clock), .reset(reset),
            .lane_in(inc_lane[gi]), .lane_out(inc_lane[gi+1])
         );
         sspg_cordic_cell #(.STEP(gi)) u_az_cell (
            .clock(clock), .reset(reset),
            .lane_in(az_lane[gi]), .lane_out(az_lane[gi+1])
         );
      end
   endgenerate

   function automatic logic [31:0] to_phase(input logic signed [ANGLE_WIDTH-1:0] a);
      logic signed [ANGLE_WIDTH+27:0] p;
      logic signed [63:0] e;
      p = a * $signed({1'b0, PHASE_MUL});
      e = {{(64-ANGLE_WIDTH-28){p[ANGLE_WIDTH+27]}}, p};
      e = e + 64'sd32768;
      return e[47:16];
   endfunction

   function automatic logic half_flip(input logic [31:0] p);
      logic [31:0] s;
      s = p + 32'h4000_0000;
      return s[31];
   endfunction

   function automatic cordic_lane_type lane_start(input logic [31:0] p, input logic v);
      cordic_lane_type l;
      logic [31:0] pf;
      pf = half_flip(p) ? (p + 32'h8000_0000) : p;
      l.valid = v;
      l.x = $signed({{(LANE_WIDTH-32){1'b0}}, CORDIC_X0});
      l.y = '0;
      l.z = $signed({{(LANE_WIDTH-32){pf[31]}}, pf});
      return l;
   endfunction

   function automatic logic [RADIUS_WIDTH-1:0] radd(input logic [RADIUS_WIDTH-1:0] r,
                                                    input logic [31:0] d);
      logic [SW-1:0] s;
      s = SW'(r) + SW'(d);
      return (s > SW'(RMAX)) ? RMAX : s[RADIUS_WIDTH-1:0];
   endfunction

   function automatic logic fits(input logic signed [CW-1:0] v);
      return (v >= ANG_LO) && (v < ANG_HI);
   endfunction

   function automatic logic signed [31:0] sat32(input logic neg, input logic [M2W-1:0] mag);
      logic [M2W-1:0] neg_mag;
      neg_mag = -mag;
      if (!neg) begin
         return (mag > M2W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(mag[31:0]);
      end
      return (mag > M2W'(33'h0_8000_0000)) ? 32'sh8000_0000 : $signed(neg_mag[31:0]);
   endfunction

   // wide views of the scan bounds
   logic signed [CW-1:0] imin_w, imax_w, amin_w, amax_w, istep_w, astep_w;
   logic signed [CW-1:0] ibound_w, abound_w, incl_w, azim_w, ni_w, na_w;
   logic [RADIUS_WIDTH-1:0] r1, r2, radius_load;
   logic restart_ok, ni_ok, na_ok;

   always_comb begin
      imin_w   = CW'(incl_min_ff);
      imax_w   = CW'(incl_max_ff);
      amin_w   = CW'(azim_min_ff);
      amax_w   = CW'(azim_max_ff);
      istep_w  = $signed({{(CW-23){1'b0}}, incl_step_ff});
      astep_w  = $signed({{(CW-23){1'b0}}, azim_step_ff});
      ibound_w = imax_w + istep_w;
      abound_w = amax_w - astep_w;
      incl_w   = CW'(incl_ff);
      azim_w   = CW'(azim_ff);
      ni_w     = incl_w + istep_w;
      na_w     = azim_w + astep_w;
      restart_ok = fits(amin_w) && fits(imin_w) && (amin_w < abound_w) &&
                   (imin_w < ibound_w);
      ni_ok = (ni_w < ibound_w) && fits(ni_w);
      na_ok = (na_w < abound_w) && fits(na_w) && fits(imin_w) && (imin_w < ibound_w);
      r1 = radd(radius_ff, radius_step_ff);
      r2 = radd(r1, radius_step_ff);
      radius_load = (SW'(radius_start_ff) > SW'(RMAX)) ? RMAX :
                    RADIUS_WIDTH'(radius_start_ff);
   end

   assign inc_lane[0] = lane_start(phase_inc_ff, state_ff == ST_LAUNCH);
   assign az_lane[0]  = lane_start(phase_az_ff, state_ff == ST_LAUNCH);

   // cordic outputs, half-turn fold undone
   logic signed [LANE_WIDTH-1:0] ci, si, ca, sa;
   always_comb begin
      ci = flip_inc_ff ? -inc_lane[CORDIC_STEPS].x : inc_lane[CORDIC_STEPS].x;
      si = flip_inc_ff ? -inc_lane[CORDIC_STEPS].y : inc_lane[CORDIC_STEPS].y;
      ca = flip_az_ff ? -az_lane[CORDIC_STEPS].x : az_lane[CORDIC_STEPS].x;
      sa = flip_az_ff ? -az_lane[CORDIC_STEPS].y : az_lane[CORDIC_STEPS].y;
   end

   logic signed [LANE_WIDTH-1:0] ci_abs, si_abs, ca_abs, sa_abs;
   assign ci_abs = ci[LANE_WIDTH-1] ? -ci : ci;
   assign si_abs = si[LANE_WIDTH-1] ? -si : si;
   assign ca_abs = ca[LANE_WIDTH-1] ? -ca : ca;
   assign sa_abs = sa[LANE_WIDTH-1] ? -sa : sa;

   // rounding of the q30 products
   logic [P1W:0] rnd_rc, rnd_z;
   logic [P2W:0] rnd_x, rnd_y;
   logic [M1W-1:0] rc_mag, z_mag;
   logic [M2W-1:0] z_mag_w, x_mag, y_mag;
   always_comb begin
      rnd_rc  = {1'b0, prod_rc_ff} + (P1W+1)'(1 << 29);
      rnd_z   = {1'b0, prod_z_ff} + (P1W+1)'(1 << 29);
      rc_mag  = rnd_rc[P1W:30];
      z_mag   = rnd_z[P1W:30];
      z_mag_w = M2W'(z_mag);
      rnd_x   = {1'b0, prod_x_ff} + (P2W+1)'(1 << 29);
      rnd_y   = {1'b0, prod_y_ff} + (P2W+1)'(1 << 29);
      x_mag   = rnd_x[P2W:30];
      y_mag   = rnd_y[P2W:30];
   end

   logic rsp_free;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         incl_min_ff     <= -24'sd274517;
         incl_max_ff     <= 24'sd274517;
         incl_step_ff    <= 23'd36602;
         azim_min_ff     <= 24'sd0;
         azim_max_ff     <= 24'sd6588420;
         azim_step_ff    <= 23'd3660;
         radius_start_ff <= 32'd1677722;
         radius_step_ff  <= 32'd1678;
      end else if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_INCL_MIN:     incl_min_ff     <= $signed(csr_chan.data[23:0]);
            CSR_INCL_MAX:     incl_max_ff     <= $signed(csr_chan.data[23:0]);
            CSR_INCL_STEP:    incl_step_ff    <= csr_chan.data[22:0];
            CSR_AZIM_MIN:     azim_min_ff     <= $signed(csr_chan.data[23:0]);
            CSR_AZIM_MAX:     azim_max_ff     <= $signed(csr_chan.data[23:0]);
            CSR_AZIM_STEP:    azim_step_ff    <= csr_chan.data[22:0];
            CSR_RADIUS_START: radius_start_ff <= csr_chan.data;
            CSR_RADIUS_STEP:  radius_step_ff  <= csr_chan.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scanning_ff  <= 1'b0;
         azim_ff      <= '0;
         incl_ff      <= '0;
         radius_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_chan.valid) begin
                  if (req_chan.restart) begin
                     azim_ff     <= ANGLE_WIDTH'(azim_min_ff);
                     incl_ff     <= ANGLE_WIDTH'(incl_min_ff);
                     radius_ff   <= radius_load;
                     scanning_ff <= restart_ok;
                  end
                  state_ff <= ST_START;
               end
            end
            ST_START: begin
               if (!scanning_ff) begin
                  state_ff <= ST_IDLE;
               end else begin
                  phase_inc_ff   <= to_phase(incl_ff);
                  phase_az_ff    <= to_phase(azim_ff);
                  item_radius_ff <= radius_ff;
                  if (ni_ok) begin
                     incl_ff   <= ni_w[ANGLE_WIDTH-1:0];
                     radius_ff <= r1;
                     eor_ff    <= 1'b0;
                     last_ff   <= 1'b0;
                  end else begin
                     // ring change: restart inclination, extra radius step
                     incl_ff   <= imin_w[ANGLE_WIDTH-1:0];
                     radius_ff <= r2;
                     eor_ff    <= 1'b1;
                     if (na_ok) begin
                        azim_ff <= na_w[ANGLE_WIDTH-1:0];
                        last_ff <= 1'b0;
                     end else begin
                        scanning_ff <= 1'b0;
                        last_ff     <= 1'b1;
                     end
                  end
                  state_ff <= ST_LAUNCH;
               end
            end
            ST_LAUNCH: begin
               flip_inc_ff <= half_flip(phase_inc_ff);
               flip_az_ff  <= half_flip(phase_az_ff);
               state_ff    <= ST_RUN;
            end
            ST_RUN: begin
               if (inc_lane[CORDIC_STEPS].valid) begin
                  ci_neg_ff <= ci[LANE_WIDTH-1];
                  si_neg_ff <= si[LANE_WIDTH-1];
                  ca_neg_ff <= ca[LANE_WIDTH-1];
                  sa_neg_ff <= sa[LANE_WIDTH-1];
                  ci_mag_ff <= ci_abs[MAG_WIDTH-1:0];
                  si_mag_ff <= si_abs[MAG_WIDTH-1:0];
                  ca_mag_ff <= ca_abs[MAG_WIDTH-1:0];
                  sa_mag_ff <= sa_abs[MAG_WIDTH-1:0];
                  state_ff  <= ST_MUL1;
               end
            end
            ST_MUL1: begin
               prod_rc_ff <= P1W'(item_radius_ff) * P1W'(ci_mag_ff);
               prod_z_ff  <= P1W'(item_radius_ff) * P1W'(si_mag_ff);
               state_ff   <= ST_RND1;
            end
            ST_RND1: begin
               rc_mag_ff <= rc_mag;
               // a zero product carries no sign
               rc_neg_ff <= ci_neg_ff && (rc_mag != '0);
               z_ff      <= sat32(si_neg_ff, z_mag_w);
               state_ff  <= ST_MUL2;
            end
            ST_MUL2: begin
               prod_x_ff <= P2W'(rc_mag_ff) * P2W'(ca_mag_ff);
               prod_y_ff <= P2W'(rc_mag_ff) * P2W'(sa_mag_ff);
               state_ff  <= ST_DONE;
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_x_ff     <= sat32(rc_neg_ff != ca_neg_ff, x_mag);
                  rsp_y_ff     <= sat32(rc_neg_ff != sa_neg_ff, y_mag);
                  rsp_z_ff     <= z_ff;
                  rsp_eor_ff   <= eor_ff;
                  rsp_last_ff  <= last_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign csr_chan.ready       = 1'b1;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pos_x       = rsp_x_ff;
   assign rsp_chan.pos_y       = rsp_y_ff;
   assign rsp_chan.pos_z       = rsp_z_ff;
   assign rsp_chan.end_of_ring = rsp_eor_ff;
   assign rsp_chan.last_point  = rsp_last_ff;

endmodule

// ===== hw/rtl/sspg_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// sspg_cordic_cell
// One rotation step of the cordic chain, registered toward the next cell.
// ----------------------------------------------------------------------------
module sspg_cordic_cell
   import sspg_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic            clock,
   input  logic            reset,
   input  cordic_lane_type lane_in,
   output cordic_lane_type lane_out
);

   cordic_lane_type lane_ff;
   cordic_lane_type lane_in_next;
   logic signed [LANE_WIDTH-1:0] dx;
   logic signed [LANE_WIDTH-1:0] dy;
   logic signed [LANE_WIDTH-1:0] angle;

   always_comb begin
      dx    = lane_in.y >>> STEP;
      dy    = lane_in.x >>> STEP;
      angle = atan_entry(STEP);
      lane_in_next.valid = lane_in.valid;
      if (!lane_in.z[LANE_WIDTH-1]) begin
         lane_in_next.x = lane_in.x - dx;
         lane_in_next.y = lane_in.y + dy;
         lane_in_next.z = lane_in.z - angle;
      end else begin
         lane_in_next.x = lane_in.x + dx;
         lane_in_next.y = lane_in.y - dy;
         lane_in_next.z = lane_in.z + angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else begin
         lane_ff.valid <= lane_in_next.valid;
      end
      lane_ff.x <= lane_in_next.x;
      lane_ff.y <= lane_in_next.y;
      lane_ff.z <= lane_in_next.z;
   end

   assign lane_out = lane_ff;

endmodule

// ===== test/spherical_scan_point_generator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spherical_scan_point_generator_top_tb
// Drives scan requests and register writes into the point generator, keeps
// its own fixed point model of the scan walk and cordic, and checks every
// result point field by field under random gaps and result stalls.
// ----------------------------------------------------------------------------
module spherical_scan_point_generator_top_tb;
   import sspg_pkg::*;

   localparam int  CYCLE_LIMIT = 3000000;
   localparam int  DRAIN_WAIT  = 40;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic               end_of_ring;
      logic               last_point;
   } scan_point_type;

   typedef enum logic [1:0] {ROW_CSR, ROW_PREDICT, ROW_NONE, ROW_ZERO} row_kind_type;

   typedef struct {
      row_kind_type  kind;
      csr_index_type idx;
      logic [31:0]   val;
   } stim_row_type;

   logic clock;
   logic reset;

   sspg_req_if req_chan ();
   sspg_rsp_if rsp_chan ();
   sspg_csr_if csr_chan ();

   spherical_scan_point_generator_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // scan model state
   logic [31:0]     reg_file [8];
   longint          azimuth_at;
   longint          incline_at;
   longint unsigned radius_at;
   bit              scan_active;

   scan_point_type  pending_points [$];
   int              error_count;
   int              cycle_count;
   int              requests_sent;
   int              points_checked;
   int              settings_used;

   const longint atan_turns [20] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2607, 1303};

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t timeout, %0d points still expected", $realtime, pending_points.size());
         $display("tb: failure");
         $finish;
      end
   end

   function automatic bit angle_fits(input longint v);
      return v >= -64'sd8388608 && v < 64'sd8388608;
   endfunction

   function automatic longint unsigned radius_sum(input longint unsigned r,
                                                  input longint unsigned d);
      longint unsigned s;
      s = r + d;
      return (s > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : s;
   endfunction

   function automatic void angle_sin_cos(input longint ang, output longint c,
                                         output longint s);
      logic [63:0] t;
      logic [31:0] p;
      logic [31:0] q;
      bit          flip;
      longint      x, y, z, dx, dy;
      int          i;
      t = 64'(ang) * 64'd42722830 + 64'd32768;
      p = t[47:16];
      q = p + 32'h4000_0000;
      flip = q[31];
      if (flip) p = p + 32'h8000_0000;
      z = longint'($signed(p));
      x = 652032874;
      y = 0;
      for (i = 0; i < 20; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - atan_turns[i];
         end else begin
            x = x + dx; y = y - dy; z = z + atan_turns[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   // product over 2^30, rounded half away from zero
   function automatic longint scale_q30(input longint a, input longint b);
      bit              neg;
      longint unsigned ma, mb, q, l, br, res;
      neg = (a < 0) != (b < 0);
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      q = (ma >> 24) * mb;
      l = (ma & 64'hFF_FFFF) * mb;
      br = ((q & 64'd63) << 24) + l + (64'd1 << 29);
      res = (q >> 6) + (br >> 30);
      return neg ? -longint'(res) : longint'(res);
   endfunction

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic longint sreg24(input csr_index_type k);
      return longint'($signed(reg_file[k][23:0]));
   endfunction

   function automatic void reset_scan_model();
      reg_file[CSR_INCL_MIN]     = 32'(-274517) & 32'hFF_FFFF;
      reg_file[CSR_INCL_MAX]     = 274517;
      reg_file[CSR_INCL_STEP]    = 36602;
      reg_file[CSR_AZIM_MIN]     = 0;
      reg_file[CSR_AZIM_MAX]     = 6588420;
      reg_file[CSR_AZIM_STEP]    = 3660;
      reg_file[CSR_RADIUS_START] = 1677722;
      reg_file[CSR_RADIUS_STEP]  = 1678;
      azimuth_at  = 0;
      incline_at  = 0;
      radius_at   = 0;
      scan_active = 0;
   endfunction

   function automatic void write_scan_reg(input csr_index_type k, input logic [31:0] v);
      case (k)
         CSR_INCL_STEP, CSR_AZIM_STEP:       reg_file[k] = v & 32'h7F_FFFF;
         CSR_RADIUS_START, CSR_RADIUS_STEP:  reg_file[k] = v;
         default:                            reg_file[k] = v & 32'hFF_FFFF;
      endcase
   endfunction

   // advances the scan model by one request, returns 1 when a point comes out
   function automatic bit advance_scan(input bit restart, output scan_point_type pt);
      longint incl_min, incl_bound, azim_min, azim_bound, incl_step, azim_step;
      longint ci, si, ca, sa, rc, ni, na;
      incl_min   = sreg24(CSR_INCL_MIN);
      incl_step  = reg_file[CSR_INCL_STEP];
      incl_bound = sreg24(CSR_INCL_MAX) + incl_step;
      azim_min   = sreg24(CSR_AZIM_MIN);
      azim_step  = reg_file[CSR_AZIM_STEP];
      azim_bound = sreg24(CSR_AZIM_MAX) - azim_step;
      pt = '0;
      if (restart) begin
         azimuth_at  = azim_min;
         incline_at  = incl_min;
         radius_at   = reg_file[CSR_RADIUS_START];
         scan_active = angle_fits(azim_min) && angle_fits(incl_min) &&
                       azim_min < azim_bound && incl_min < incl_bound;
      end
      if (!scan_active) return 0;
      angle_sin_cos(incline_at, ci, si);
      angle_sin_cos(azimuth_at, ca, sa);
      rc = scale_q30(longint'(radius_at), ci);
      pt.pos_x = clamp32(scale_q30(rc, ca));
      pt.pos_y = clamp32(scale_q30(rc, sa));
      pt.pos_z = clamp32(scale_q30(longint'(radius_at), si));
      radius_at = radius_sum(radius_at, reg_file[CSR_RADIUS_STEP]);
      ni = incline_at + incl_step;
      if (ni < incl_bound && angle_fits(ni)) begin
         incline_at = ni;
      end else begin
         na = azimuth_at + azim_step;
         pt.end_of_ring = 1;
         incline_at = incl_min;
         radius_at = radius_sum(radius_at, reg_file[CSR_RADIUS_STEP]);
         if (na < azim_bound && angle_fits(na) && angle_fits(incl_min) &&
             incl_min < incl_bound) begin
            azimuth_at = na;
         end else begin
            scan_active = 0;
            pt.last_point = 1;
         end
      end
      return 1;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // called at a rising edge; leaves at the edge where the request is taken or, after a random gap, with valid dropped
   task automatic send_request(input bit restart, input row_kind_type kind);
      scan_point_type pt;
      bit             has_point;
      int             gap;
      req_chan.valid   <= 1'b1;
      req_chan.restart <= restart;
      forever begin
         @(negedge clock);
         if (req_chan.ready) break;
      end
      @(posedge clock);
      requests_sent++;
      has_point = advance_scan(restart, pt);
      if (kind == ROW_NONE && has_point) begin
         $display("%0t table row expects no point, model gives one", $realtime);
         error_count++;
      end
      if (kind == ROW_ZERO) begin
         if (!has_point || pt.pos_x != 0 || pt.pos_y != 0 || pt.pos_z != 0) begin
            $display("%0t table row expects a zero point, model disagrees", $realtime);
            error_count++;
         end
         pt.pos_x = 0; pt.pos_y = 0; pt.pos_z = 0;
      end
      if (has_point) pending_points = {pending_points, pt};
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      int n;
      n = 0;
      req_chan.valid <= 1'b0;
      while (pending_points.size() != 0 && n < 200000) begin
         @(posedge clock);
         n++;
      end
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type k, input logic [31:0] v);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= k;
      csr_chan.data  <= v;
      forever begin
         @(negedge clock);
         if (csr_chan.ready) break;
      end
      @(posedge clock);
      write_scan_reg(k, v);
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic longint clip_angle(input longint v);
      if (v > 64'sd8388607) return 8388607;
      if (v < -64'sd8388608) return -8388608;
      return v;
   endfunction

   // random setting, mostly small scans so that rings and scan ends recur
   task automatic random_setting();
      longint imin, amin, istep, astep, imax, amax;
      imin  = longint'($signed(24'($urandom())));
      amin  = longint'($signed(24'($urandom())));
      istep = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8388607)
                                          : $urandom_range(1, 300000);
      astep = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8388607)
                                          : $urandom_range(1, 300000);
      imax = ($urandom_range(0, 7) == 0) ? longint'($signed(24'($urandom())))
             : clip_angle(imin + istep * $urandom_range(0, 6) - $urandom_range(0, 2));
      amax = ($urandom_range(0, 7) == 0) ? longint'($signed(24'($urandom())))
             : clip_angle(amin + astep * $urandom_range(1, 6) + $urandom_range(0, 2));
      write_reg(CSR_INCL_MIN, 32'(imin));
      write_reg(CSR_INCL_MAX, 32'(imax));
      write_reg(CSR_INCL_STEP, 32'(istep));
      write_reg(CSR_AZIM_MIN, 32'(amin));
      write_reg(CSR_AZIM_MAX, 32'(amax));
      write_reg(CSR_AZIM_STEP, 32'(astep));
      write_reg(CSR_RADIUS_START, ($urandom_range(0, 3) == 0) ? $urandom()
                                  : $urandom_range(0, 50000000));
      write_reg(CSR_RADIUS_STEP, ($urandom_range(0, 5) == 0) ? $urandom()
                                 : $urandom_range(0, 2000000));
      settings_used++;
   endtask

   // result side: ready toggles in runs, sometimes long stalls
   initial begin
      int run, stall;
      rsp_chan.ready = 1'b0;
      @(negedge reset);
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 12);
         stall = pick_gap();
         rsp_chan.ready <= 1'b1;
         repeat (run) @(posedge clock);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   always @(negedge clock) begin
      scan_point_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_points.size() == 0) begin
            $display("%0t unexpected point x=%0d y=%0d z=%0d", $realtime,
                     rsp_chan.pos_x, rsp_chan.pos_y, rsp_chan.pos_z);
            error_count++;
         end else begin
            want = pending_points.pop_front();
            points_checked++;
            if (rsp_chan.pos_x !== want.pos_x) begin
               $display("%0t pos_x expected %0d got %0d", $realtime, want.pos_x, rsp_chan.pos_x);
               error_count++;
            end
            if (rsp_chan.pos_y !== want.pos_y) begin
               $display("%0t pos_y expected %0d got %0d", $realtime, want.pos_y, rsp_chan.pos_y);
               error_count++;
            end
            if (rsp_chan.pos_z !== want.pos_z) begin
               $display("%0t pos_z expected %0d got %0d", $realtime, want.pos_z, rsp_chan.pos_z);
               error_count++;
            end
            if (rsp_chan.end_of_ring !== want.end_of_ring) begin
               $display("%0t end_of_ring expected %0b got %0b", $realtime,
                        want.end_of_ring, rsp_chan.end_of_ring);
               error_count++;
            end
            if (rsp_chan.last_point !== want.last_point) begin
               $display("%0t last_point expected %0b got %0b", $realtime,
                        want.last_point, rsp_chan.last_point);
               error_count++;
            end
         end
      end
   end

   initial begin
      stim_row_type table_rows [$];
      int           i, k, burst;
      bit           rst;

      clock = 0;
      reset = 1;
      cycle_count = 0;
      error_count = 0;
      requests_sent = 0;
      points_checked = 0;
      settings_used = 1;
      req_chan.valid = 0;
      req_chan.restart = 0;
      csr_chan.valid = 0;
      csr_chan.index = CSR_INCL_MIN;
      csr_chan.data = 0;
      reset_scan_model();

      table_rows = '{
         '{ROW_NONE, CSR_INCL_MIN, 32'd0},          // advance with no scan active
         '{ROW_PREDICT, CSR_INCL_MIN, 32'd1},       // default pattern
         '{ROW_PREDICT, CSR_INCL_MIN, 32'd0},
         '{ROW_PREDICT, CSR_INCL_MIN, 32'd0},
         // one point per ring, two rings, zero radius
         '{ROW_CSR, CSR_INCL_MIN, 32'd0},
         '{ROW_CSR, CSR_INCL_MAX, 32'd0},
         '{ROW_CSR, CSR_INCL_STEP, 32'd1},
         '{ROW_CSR, CSR_AZIM_MIN, 32'd0},
         '{ROW_CSR, CSR_AZIM_MAX, 32'd3},
         '{ROW_CSR, CSR_AZIM_STEP, 32'd1},
         '{ROW_CSR, CSR_RADIUS_START, 32'd0},
         '{ROW_CSR, CSR_RADIUS_STEP, 32'd0},
         '{ROW_ZERO, CSR_INCL_MIN, 32'd1},
         '{ROW_ZERO, CSR_INCL_MIN, 32'd0},
         '{ROW_NONE, CSR_INCL_MIN, 32'd0},          // scan already over
         // empty scan: first azimuth fails its bound
         '{ROW_CSR, CSR_AZIM_MAX, 32'd0},
         '{ROW_NONE, CSR_INCL_MIN, 32'd1},
         // extremes: full angle range, radius and coordinates saturate
         '{ROW_CSR, CSR_INCL_MIN, 32'h80_0000},
         '{ROW_CSR, CSR_INCL_MAX, 32'h7F_FFFF},
         '{ROW_CSR, CSR_INCL_STEP, 32'h7F_FFFF},
         '{ROW_CSR, CSR_AZIM_MIN, 32'h80_0000},
         '{ROW_CSR, CSR_AZIM_MAX, 32'h7F_FFFF},
         '{ROW_CSR, CSR_AZIM_STEP, 32'h7F_FFFF},
         '{ROW_CSR, CSR_RADIUS_START, 32'hFFFF_FFFF},
         '{ROW_CSR, CSR_RADIUS_STEP, 32'hFFFF_FFFF},
         '{ROW_PREDICT, CSR_INCL_MIN, 32'd1},
         '{ROW_PREDICT, CSR_INCL_MIN, 32'd0},
         '{ROW_PREDICT, CSR_INCL_MIN, 32'd0},
         '{ROW_PREDICT, CSR_INCL_MIN, 32'd0},
         '{ROW_PREDICT, CSR_INCL_MIN, 32'd0},
         '{ROW_PREDICT, CSR_INCL_MIN, 32'd0},
         '{ROW_PREDICT, CSR_INCL_MIN, 32'd0}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < table_rows.size(); i++) begin
         if (table_rows[i].kind == ROW_CSR) begin
            if (i == 0 || table_rows[i-1].kind != ROW_CSR) wait_idle();
            write_reg(table_rows[i].idx, table_rows[i].val);
         end else begin
            send_request(table_rows[i].val[0], table_rows[i].kind);
         end
      end

      // random scans with fresh settings between idle points
      for (k = 0; k < 12; k++) begin
         wait_idle();
         random_setting();
         burst = 100;
         for (i = 0; i < burst; i++) begin
            rst = scan_active ? ($urandom_range(0, 19) == 0) : ($urandom_range(0, 3) != 0);
            send_request(rst, ROW_PREDICT);
         end
      end

      wait_idle();
      $display("covered %0d requests, %0d points checked over %0d register settings",
               requests_sent, points_checked, settings_used);
      if (error_count == 0 && pending_points.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/sspg_pkg.sv
hw/rtl/sspg_if.sv
hw/rtl/sspg_cordic_cell.sv
hw/rtl/spherical_scan_point_generator_top.sv
test/spherical_scan_point_generator_top_tb.sv
